// ===== rtl/core/owb_pkg.sv =====
// Shared types and constants for the single-wire bus master.
// Used by every module of the block; depends on nothing else.
package owb_pkg;

  localparam int NumRegs         = 8;
  localparam int RegW            = 10;
  localparam int AddrW           = 5;
  localparam int DataW           = 32;
  localparam int TimeBitsDefault = 10;

  // Register indexes
  localparam logic [2:0] RegResetLow   = 3'd0;
  localparam logic [2:0] RegPresWait   = 3'd1;
  localparam logic [2:0] RegResetTail  = 3'd2;
  localparam logic [2:0] RegWrOneLow   = 3'd3;
  localparam logic [2:0] RegWrSlot     = 3'd4;
  localparam logic [2:0] RegRdLow      = 3'd5;
  localparam logic [2:0] RegRdSample   = 3'd6;
  localparam logic [2:0] RegRdTail     = 3'd7;

  typedef logic [NumRegs-1:0][RegW-1:0] owb_cfg_t;

  localparam owb_cfg_t RegResetVals = {
    10'd53, 10'd10, 10'd3, 10'd60, 10'd5, 10'd410, 10'd70, 10'd480
  };

  typedef enum logic [1:0] {
    OpNone  = 2'd0,
    OpReset = 2'd1,
    OpWrite = 2'd2,
    OpRead  = 2'd3
  } owb_op_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] write_byte;
    logic       line_level;
    logic       tick_us;
  } owb_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } owb_res_t;

endpackage

// ===== rtl/core/owb_regs.sv =====
// Configuration register file with an APB-style access port.
// Depends on owb_pkg for register layout and reset values.
module owb_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [owb_pkg::AddrW-1:0] paddr,
  input  logic [owb_pkg::DataW-1:0] pwdata,
  output logic [owb_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output owb_pkg::owb_cfg_t        cfg_o
);
  import owb_pkg::*;

  owb_cfg_t   regs_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[AddrW-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {{(DataW-RegW){1'b0}}, regs_q[idx]};
  assign cfg_o  = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= RegResetVals;
    end else if (wr_en) begin
      regs_q[idx] <= pwdata[RegW-1:0];
    end
  end

endmodule

// ===== rtl/core/owb_fsm.sv =====
// Bus timing state machine: phase, tick counter, bit and byte state.
// Computes the result for one item from the current state; depends on owb_pkg.
module owb_fsm #(
  parameter int TimeBits = owb_pkg::TimeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  owb_pkg::owb_item_t   item_i,
  input  owb_pkg::owb_cfg_t    cfg_i,
  output owb_pkg::owb_res_t    res_o
);
  import owb_pkg::*;

  localparam int LimW = (TimeBits > RegW) ? TimeBits : RegW;
  localparam logic [TimeBits-1:0] CountMax = '1;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhRstLow  = 4'd1,
    PhRstWait = 4'd2,
    PhRstTail = 4'd3,
    PhWrLow   = 4'd4,
    PhWrRest  = 4'd5,
    PhRdLow   = 4'd6,
    PhRdWait  = 4'd7,
    PhRdTail  = 4'd8
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [TimeBits-1:0] count_q, count_d, count_inc;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          shift_q, shift_d;
  logic                pres_q, pres_d;
  logic [7:0]          last_q, last_d;
  logic                done;
  logic                slot_end;
  logic [RegW-1:0]     rest_len;

  // Compare the counter against a length clipped to the counter range
  function automatic logic expired(input logic [TimeBits-1:0] cnt,
                                   input logic [RegW-1:0] len);
    logic [LimW-1:0] len_x;
    logic [LimW-1:0] lim;
    len_x = LimW'(len);
    lim   = (len_x > LimW'(CountMax)) ? LimW'(CountMax) : len_x;
    return LimW'(cnt) >= lim;
  endfunction

  assign rest_len = (cfg_i[RegWrSlot] > cfg_i[RegWrOneLow]) ?
                    (cfg_i[RegWrSlot] - cfg_i[RegWrOneLow]) : '0;
  assign count_inc = (item_i.tick_us && count_q != CountMax) ?
                     (count_q + TimeBits'(1)) : count_q;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    pres_d   = pres_q;
    last_d   = last_q;
    done     = 1'b0;
    slot_end = 1'b0;

    if (phase_q == PhIdle) begin
      count_d = '0;
      if (item_i.op == OpReset) begin
        phase_d = PhRstLow;
      end else if (item_i.op == OpWrite) begin
        shift_d = item_i.write_byte;
        bit_d   = '0;
        phase_d = PhWrLow;
      end else if (item_i.op == OpRead) begin
        shift_d = '0;
        bit_d   = '0;
        phase_d = PhRdLow;
      end
    end else begin
      count_d = count_inc;
      case (phase_q)
        PhRstLow: begin
          if (expired(count_inc, cfg_i[RegResetLow])) begin
            phase_d = PhRstWait;
            count_d = '0;
          end
        end
        PhRstWait: begin
          if (expired(count_inc, cfg_i[RegPresWait])) begin
            pres_d  = ~item_i.line_level;
            phase_d = PhRstTail;
            count_d = '0;
          end
        end
        PhRstTail: begin
          if (expired(count_inc, cfg_i[RegResetTail])) begin
            phase_d = PhIdle;
            count_d = '0;
            done    = 1'b1;
          end
        end
        PhWrLow: begin
          if (shift_q[0]) begin
            if (expired(count_inc, cfg_i[RegWrOneLow])) begin
              phase_d = PhWrRest;
              count_d = '0;
            end
          end else begin
            slot_end = expired(count_inc, cfg_i[RegWrSlot]);
          end
        end
        PhWrRest: begin
          slot_end = expired(count_inc, rest_len);
        end
        PhRdLow: begin
          if (expired(count_inc, cfg_i[RegRdLow])) begin
            phase_d = PhRdWait;
            count_d = '0;
          end
        end
        PhRdWait: begin
          if (expired(count_inc, cfg_i[RegRdSample])) begin
            shift_d = shift_q | (8'(item_i.line_level) << bit_q);
            phase_d = PhRdTail;
            count_d = '0;
          end
        end
        PhRdTail: begin
          if (expired(count_inc, cfg_i[RegRdTail])) begin
            count_d = '0;
            if (bit_q == 3'd7) begin
              last_d  = shift_q;
              bit_d   = '0;
              phase_d = PhIdle;
              done    = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = PhRdLow;
            end
          end
        end
        default: begin
          phase_d = PhIdle;
          count_d = '0;
        end
      endcase

      // Finish a write slot: next bit or end of byte
      if (slot_end) begin
        count_d = '0;
        if (bit_q == 3'd7) begin
          bit_d   = '0;
          phase_d = PhIdle;
          done    = 1'b1;
        end else begin
          bit_d   = bit_q + 3'd1;
          shift_d = shift_q >> 1;
          phase_d = PhWrLow;
        end
      end
    end
  end

  always_comb begin
    res_o.drive_low = (phase_d == PhRstLow) || (phase_d == PhWrLow) || (phase_d == PhRdLow);
    res_o.busy_res  = (phase_d != PhIdle);
    res_o.done_res  = done;
    res_o.presence  = pres_d;
    res_o.read_data = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      count_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
      last_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== rtl/core/one_wire_bus_master_unit.sv =====
// Single-wire bus master: reset with presence detect, byte write and byte
// read, each bit timed in microsecond ticks carried by the items. One item
// is accepted per clock unless a stalled result blocks the input, and its
// result is offered from the output register. An input register feeds the
// timing state machine, whose result lands in an output register. A stalled
// result holds that register, and it blocks the input only once the input
// register is also full. The state machine advances once per processed item.
// Register writes through the APB-style port take effect at once, so make
// them while no item is in flight. Depends on owb_pkg, owb_regs and owb_fsm.
module one_wire_bus_master_unit #(
  parameter int TimeBits = owb_pkg::TimeBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [owb_pkg::AddrW-1:0] paddr,
  input  logic [owb_pkg::DataW-1:0] pwdata,
  output logic [owb_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                op_i,
  input  logic [7:0]                write_byte_i,
  input  logic                      line_level_i,
  input  logic                      tick_us_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      drive_low_o,
  output logic                      busy_res_o,
  output logic                      done_res_o,
  output logic                      presence_o,
  output logic [7:0]                read_data_o
);
  import owb_pkg::*;

  owb_cfg_t  cfg;
  owb_item_t item_q;
  owb_res_t  res, res_q;
  logic      in_valid_q, out_valid_q;
  logic      advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  owb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owb_fsm #(
    .TimeBits (TimeBits)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.op         <= op_i;
      item_q.write_byte <= write_byte_i;
      item_q.line_level <= line_level_i;
      item_q.tick_us    <= tick_us_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = res_q.drive_low;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign presence_o  = res_q.presence;
  assign read_data_o = res_q.read_data;

endmodule

// ===== rtl/core/owb_checker.sv =====
// Port-level checks for the single-wire bus master, bound to the top level.
// Depends on owb_pkg and one_wire_bus_master_unit.
module owb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic pready,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic drive_low_o,
  input logic busy_res_o,
  input logic done_res_o
);
  import owb_pkg::*;

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A finished command leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while busy");

  // The line is only pulled during a command
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_low_o |-> busy_res_o)
    else $error("line driven while idle");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind one_wire_bus_master_unit owb_checker u_owb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .drive_low_o (drive_low_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o)
);
